// ===== hw/rtl/bcf_pkg.sv =====
// Shared constants, types and the dot mask function of the braille cell framebuffer.
`timescale 1ns / 1ps

package bcf_pkg;

    localparam int FRAME_WIDTH_PX  = 256;
    localparam int FRAME_HEIGHT_PX = 128;

    localparam int CELLS_W   = (FRAME_WIDTH_PX + 1) / 2;
    localparam int CELLS_H   = (FRAME_HEIGHT_PX + 3) / 4;
    localparam int NUM_CELLS = CELLS_W * CELLS_H;
    localparam int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    localparam int DOTS_W = 8;
    localparam int CODE_W = 14;
    localparam int POS_W  = 17;

    localparam logic [7:0]        LIT_THRESHOLD = 8'd128;
    localparam logic [CODE_W-1:0] BRAILLE_BASE  = 14'h2800;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DOTS_W-1:0] dots_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        dots_t data;
    } wr_req_t;

    function automatic dots_t dot_mask(input logic [2:0] slot);
        dots_t mask;
        case (slot)
            3'd0:    mask = 8'b0000_0001;
            3'd1:    mask = 8'b0000_1000;
            3'd2:    mask = 8'b0000_0010;
            3'd3:    mask = 8'b0001_0000;
            3'd4:    mask = 8'b0000_0100;
            3'd5:    mask = 8'b0010_0000;
            3'd6:    mask = 8'b0100_0000;
            3'd7:    mask = 8'b1000_0000;
            default: mask = 8'b0000_0000;
        endcase
        return mask;
    endfunction

endpackage

// ===== hw/rtl/bcf_dot_store.sv =====
// Cell dot memory with one read port, one write port and a clearing sweep after reset.
`timescale 1ns / 1ps

module bcf_dot_store
    import bcf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rd_en,
    input  addr_t   rd_addr,
    output dots_t   rd_data,
    input  wr_req_t wr,
    output logic    busy
);

    dots_t mem [NUM_CELLS];
    dots_t rd_data_reg;
    logic  clr_busy_reg;
    logic  clr_busy_next;
    addr_t clr_addr_reg;
    addr_t clr_addr_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == addr_t'(NUM_CELLS - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + addr_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

    a_no_write_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !wr.en)
        else $error("Item write issued during the clearing sweep.");

    a_no_read_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !rd_en)
        else $error("Item read issued during the clearing sweep.");

endmodule

// ===== hw/rtl/braille_cell_framebuffer.sv =====
// Top level of the braille cell framebuffer: request pipeline, forwarding and result register.
`timescale 1ns / 1ps

// The block stores a pixel frame as 2x4 braille cells in one memory of 8-bit dot masks.
// Requests arrive on the s_ channel: tuser selects a pixel write (0) or a cell read (1).
// A write sets or clears one dot of its cell and reports whether it landed in the frame.
// A read returns the Unicode braille code of one cell. Every request gives one beat on m_.
// Each request is a read-modify-write of one memory entry: the memory is read at the
// accept edge, and the entry is modified and written back at the edge where the result
// enters the output register. A write followed at once by an access to the same cell
// is served by forwarding the written value, so one request per cycle is sustained
// while the receiver does not stall.
// After reset the memory is cleared by a sweep over all NUM_CELLS entries (4096 with the
// default frame), during which s_tready stays low. When the receiver stalls, the output
// register and the request stage hold their contents; s_tready falls when both are full.

module braille_cell_framebuffer
    import bcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // dest_x[15:0], dest_y[31:16], img_x[43:32], img_y[55:44], pixel_value[63:56],
    // cell_x[70:64], cell_y[75:71], zero fill[79:76]
    input  logic [79:0] s_tdata,
    // req_type[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // char_code[13:0], written[14], zero fill[15]
    output logic [15:0] m_tdata
);

    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [11:0] img_x;
    logic [11:0] img_y;
    logic [7:0]  pixel_value;
    logic [6:0]  cell_x;
    logic [4:0]  cell_y;
    logic        req_type;

    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             wr_ok;
    logic             rd_ok;
    addr_t            wr_addr;
    addr_t            rd_addr_cell;
    addr_t            req_addr;

    logic accept;
    logic advance;
    logic p1_load;
    logic store_busy;

    logic  p1_valid_reg;
    logic  p1_write_reg;
    logic  p1_ok_reg;
    logic  p1_lit_reg;
    addr_t p1_addr_reg;
    dots_t p1_mask_reg;
    logic  fwd_hit_reg;
    dots_t fwd_data_reg;

    dots_t   rd_data;
    dots_t   cur_dots;
    wr_req_t wr;

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_written_reg;
    logic [CODE_W-1:0] out_code_next;
    logic              out_written_next;

    assign dest_x      = s_tdata[15:0];
    assign dest_y      = s_tdata[31:16];
    assign img_x       = s_tdata[43:32];
    assign img_y       = s_tdata[55:44];
    assign pixel_value = s_tdata[63:56];
    assign cell_x      = s_tdata[70:64];
    assign cell_y      = s_tdata[75:71];
    assign req_type    = s_tuser[0];

    assign pos_x = {1'b0, dest_x} + {5'b0, img_x};
    assign pos_y = {1'b0, dest_y} + {5'b0, img_y};

    assign wr_ok = (32'(pos_x) < FRAME_WIDTH_PX) && (32'(pos_y) < FRAME_HEIGHT_PX);
    assign rd_ok = (32'(cell_x) < CELLS_W) && (32'(cell_y) < CELLS_H);

    assign wr_addr      = ADDR_W'(32'(pos_y >> 2) * CELLS_W + 32'(pos_x >> 1));
    assign rd_addr_cell = ADDR_W'(32'(cell_y) * CELLS_W + 32'(cell_x));
    assign req_addr     = (req_type == REQ_WRITE) ? wr_addr : rd_addr_cell;

    assign advance  = !out_valid_reg || m_tready;
    assign p1_load  = !p1_valid_reg || advance;
    assign s_tready = !store_busy && p1_load;
    assign accept   = s_tvalid && s_tready;

    bcf_dot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .busy    (store_busy)
    );

    assign cur_dots = fwd_hit_reg ? fwd_data_reg : rd_data;

    always_comb
    begin
        wr.en   = p1_valid_reg && advance && (p1_write_reg == REQ_WRITE) && p1_ok_reg;
        wr.addr = p1_addr_reg;
        wr.data = p1_lit_reg ? (cur_dots | p1_mask_reg) : (cur_dots & ~p1_mask_reg);
    end

    always_comb
    begin
        if (p1_write_reg == REQ_WRITE)
        begin
            out_code_next    = '0;
            out_written_next = p1_ok_reg;
        end
        else
        begin
            out_code_next    = p1_ok_reg ? (BRAILLE_BASE + {6'b0, cur_dots}) : BRAILLE_BASE;
            out_written_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_load)
            begin
                p1_valid_reg <= accept;
            end
            if (advance)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_write_reg <= req_type;
            p1_ok_reg    <= (req_type == REQ_WRITE) ? wr_ok : rd_ok;
            p1_lit_reg   <= pixel_value >= LIT_THRESHOLD;
            p1_addr_reg  <= req_addr;
            p1_mask_reg  <= dot_mask({pos_y[1:0], pos_x[0]});
            fwd_hit_reg  <= wr.en && (wr.addr == req_addr);
            fwd_data_reg <= wr.data;
        end
        if (advance && p1_valid_reg)
        begin
            out_code_reg    <= out_code_next;
            out_written_reg <= out_written_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_written_reg, out_code_reg};

    a_ready_low_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !s_tready)
        else $error("Request beat taken during the clearing sweep.");

    a_written_has_no_code : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[14]) |-> (m_tdata[13:0] == 14'd0))
        else $error("Landed write carries a nonzero character code.");

    a_read_code_in_braille_block : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[13:0] != 14'd0)) |-> (m_tdata[13:8] == BRAILLE_BASE[13:8]))
        else $error("Read result lies outside the braille code block.");

    a_write_only_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> out_valid_reg && out_written_reg)
        else $error("Memory write without a matching landed-write result.");

endmodule
